// ----- hw/rtl/calendar_time_normalizer_top_defines.svh -----
// Assertion macros for the calendar time normalizer checker
`ifndef CALENDAR_TIME_NORMALIZER_TOP_DEFINES_SVH
`define CALENDAR_TIME_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CTN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CTN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ctn_pkg.sv -----
package ctn_pkg;

    localparam int DIV_W   = 18;
    localparam int DVS_W   = 9;
    localparam int MAG_W   = DIV_W - 1;
    localparam int RCP_W   = 18;
    localparam int SFT_W   = 5;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam int QD_W    = MAG_W + DVS_W;

    localparam logic [DVS_W-1:0] SEC_PER_MIN  = 9'd60;
    localparam logic [DVS_W-1:0] MIN_PER_HOUR = 9'd60;
    localparam logic [DVS_W-1:0] HOUR_PER_DAY = 9'd24;
    localparam logic [DVS_W-1:0] MON_PER_YEAR = 9'd12;
    localparam logic [DVS_W-1:0] CYCLE_400    = 9'd400;
    localparam logic [DVS_W-1:0] CYCLE_100    = 9'd100;
    localparam logic [DVS_W-1:0] DAYS_PER_WK  = 9'd7;

    // ceil(2^shift / divisor), exact for magnitudes below 2^MAG_W
    localparam logic [RCP_W-1:0] RCP_WK  = 18'd149797;
    localparam logic [SFT_W-1:0] SFT_WK  = 5'd20;
    localparam logic [RCP_W-1:0] RCP_MON = 18'd174763;
    localparam logic [SFT_W-1:0] SFT_MON = 5'd21;
    localparam logic [RCP_W-1:0] RCP_DAY = 18'd174763;
    localparam logic [SFT_W-1:0] SFT_DAY = 5'd22;
    localparam logic [RCP_W-1:0] RCP_MIN = 18'd139811;
    localparam logic [SFT_W-1:0] SFT_MIN = 5'd23;
    localparam logic [RCP_W-1:0] RCP_100 = 18'd167773;
    localparam logic [SFT_W-1:0] SFT_100 = 5'd24;
    localparam logic [RCP_W-1:0] RCP_400 = 18'd167773;
    localparam logic [SFT_W-1:0] SFT_400 = 5'd26;

    localparam logic [8:0] R400_LAST = 9'd399;
    localparam logic [3:0] MON_LAST  = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_MON,
        ST_Y400,
        ST_BORROW,
        ST_CARRY,
        ST_CHECK,
        ST_C100,
        ST_C400,
        ST_WDAY,
        ST_OUT
    } ctn_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quot;
        logic [DVS_W-1:0]        rem;
    } div_rsp_t;

    function automatic logic is_leap(input logic [8:0] r400);
        logic century;
        century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            4'd1:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2) && (mon <= MON_LAST))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ----- hw/rtl/ctn_div.sv -----
module ctn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ctn_pkg::div_req_t req,
    output ctn_pkg::div_rsp_t rsp
);

    logic [2:0]                    stg_reg, stg_next;
    logic                          done_reg, done_next;
    logic                          neg_reg, neg_next;
    logic [ctn_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [ctn_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic [ctn_pkg::RCP_W-1:0]     rcp_reg, rcp_next;
    logic [ctn_pkg::SFT_W-1:0]     sft_reg, sft_next;
    logic [ctn_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [ctn_pkg::MAG_W-1:0]     quo_reg, quo_next;
    logic [ctn_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [ctn_pkg::RCP_W-1:0]     rcp;
    logic [ctn_pkg::SFT_W-1:0]     sft;
    logic [ctn_pkg::QD_W-1:0]      qd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            stg_reg  <= stg_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        dvs_reg  <= dvs_next;
        mag_reg  <= mag_next;
        rcp_reg  <= rcp_next;
        sft_reg  <= sft_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        unique case (req.divisor)
            ctn_pkg::DAYS_PER_WK:
            begin
                rcp = ctn_pkg::RCP_WK;
                sft = ctn_pkg::SFT_WK;
            end
            ctn_pkg::MON_PER_YEAR:
            begin
                rcp = ctn_pkg::RCP_MON;
                sft = ctn_pkg::SFT_MON;
            end
            ctn_pkg::HOUR_PER_DAY:
            begin
                rcp = ctn_pkg::RCP_DAY;
                sft = ctn_pkg::SFT_DAY;
            end
            ctn_pkg::SEC_PER_MIN:
            begin
                rcp = ctn_pkg::RCP_MIN;
                sft = ctn_pkg::SFT_MIN;
            end
            ctn_pkg::CYCLE_100:
            begin
                rcp = ctn_pkg::RCP_100;
                sft = ctn_pkg::SFT_100;
            end
            ctn_pkg::CYCLE_400:
            begin
                rcp = ctn_pkg::RCP_400;
                sft = ctn_pkg::SFT_400;
            end
            default:
            begin
                rcp = '0;
                sft = '0;
            end
        endcase
        qd        = {{ctn_pkg::DVS_W{1'b0}}, quo_reg} * {{ctn_pkg::MAG_W{1'b0}}, dvs_reg};
        stg_next  = {stg_reg[1:0], req.start};
        done_next = stg_reg[2];
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        mag_next  = mag_reg;
        rcp_next  = rcp_reg;
        sft_next  = sft_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            // floor division of a negative value: divide ~a, then flip back
            neg_next = req.dividend[ctn_pkg::DIV_W-1];
            dvs_next = req.divisor;
            mag_next = req.dividend[ctn_pkg::DIV_W-1] ? ~req.dividend[ctn_pkg::MAG_W-1:0]
                                                      : req.dividend[ctn_pkg::MAG_W-1:0];
            rcp_next = rcp;
            sft_next = sft;
        end
        if (stg_reg[0])
        begin
            prod_next = {{ctn_pkg::RCP_W{1'b0}}, mag_reg} * {{ctn_pkg::MAG_W{1'b0}}, rcp_reg};
        end
        if (stg_reg[1])
        begin
            quo_next = ctn_pkg::MAG_W'(prod_reg >> sft_reg);
        end
        if (stg_reg[2])
        begin
            rem_next = ctn_pkg::DVS_W'({{ctn_pkg::DVS_W{1'b0}}, mag_reg} - qd);
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = neg_reg ? $signed(~{1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        rsp.rem  = neg_reg ? ctn_pkg::DVS_W'(dvs_reg - 1'b1 - rem_reg) : rem_reg;
    end

endmodule

// ----- hw/rtl/calendar_time_normalizer_top.sv -----
// Five floor divisions, a month-by-month day fold, then three more floor divisions, all
// eight on one shared reciprocal divider; the last three are skipped when the year is out
// of range. A new transaction is accepted only after the last result is loaded into the
// output registers; in_ready is high only while idle.
// Reset: asynchronous, active low; clears the sequencer and out_valid.
module calendar_time_normalizer_top #(
    parameter int MAX_YEAR_OFFSET = 4095,
    parameter int BASE_YEAR       = 1900
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] second_in,
    input  logic signed [15:0] minute_in,
    input  logic signed [15:0] hour_in,
    input  logic signed [15:0] day_in,
    input  logic signed [15:0] month_in,
    input  logic signed [12:0] year_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         second_out,
    output logic [5:0]         minute_out,
    output logic [4:0]         hour_out,
    output logic [4:0]         day_out,
    output logic [3:0]         month_out,
    output logic [11:0]        year_out,
    output logic [8:0]         day_of_year,
    output logic [2:0]         weekday,
    output logic               out_of_range
);

    localparam int W = ctn_pkg::DIV_W;
    localparam logic signed [W-1:0] MAX_S  = W'(MAX_YEAR_OFFSET);
    localparam logic signed [W-1:0] BASE_S = W'(BASE_YEAR);

    ctn_pkg::ctn_state_t state_reg, state_next;
    logic                issued_reg, issued_next;
    logic                out_valid_reg, out_valid_next;
    logic                oor_reg, oor_next;

    logic signed [15:0]  sec_reg, sec_next;
    logic signed [15:0]  mon_reg, mon_next;
    logic signed [W-1:0] min_reg, min_next;
    logic signed [W-1:0] hour_reg, hour_next;
    logic signed [W-1:0] mday_reg, mday_next;
    logic signed [W-1:0] year_reg, year_next;
    logic signed [W-1:0] am1_reg, am1_next;
    logic [8:0]          r400_reg, r400_next;
    logic [8:0]          yday_reg, yday_next;
    logic [7:0]          q100_reg, q100_next;
    logic [7:0]          q400_reg, q400_next;
    logic [2:0]          wday_reg, wday_next;

    logic [5:0]  second_reg, second_next;
    logic [5:0]  minute_reg, minute_next;
    logic [4:0]  hour_o_reg, hour_o_next;
    logic [4:0]  day_o_reg, day_o_next;
    logic [3:0]  month_o_reg, month_o_next;
    logic [11:0] year_o_reg, year_o_next;
    logic [8:0]  doy_reg, doy_next;
    logic [2:0]  wd_o_reg, wd_o_next;
    logic        oor_o_reg, oor_o_next;

    ctn_pkg::div_req_t div_req;
    ctn_pkg::div_rsp_t div_rsp;
    logic              div_state;
    logic              div_fire;

    logic [3:0]          mon_idx;
    logic [3:0]          mon_b;
    logic [8:0]          r400_b;
    logic [8:0]          r400_c;
    logic [4:0]          len_b;
    logic [4:0]          len_c;
    logic                leap_now;
    logic signed [W-1:0] wk_sum;

    ctn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctn_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg     <= oor_next;
        sec_reg     <= sec_next;
        mon_reg     <= mon_next;
        min_reg     <= min_next;
        hour_reg    <= hour_next;
        mday_reg    <= mday_next;
        year_reg    <= year_next;
        am1_reg     <= am1_next;
        r400_reg    <= r400_next;
        yday_reg    <= yday_next;
        q100_reg    <= q100_next;
        q400_reg    <= q400_next;
        wday_reg    <= wday_next;
        second_reg  <= second_next;
        minute_reg  <= minute_next;
        hour_o_reg  <= hour_o_next;
        day_o_reg   <= day_o_next;
        month_o_reg <= month_o_next;
        year_o_reg  <= year_o_next;
        doy_reg     <= doy_next;
        wd_o_reg    <= wd_o_next;
        oor_o_reg   <= oor_o_next;
    end

    always_comb
    begin
        mon_idx  = mon_reg[3:0];
        leap_now = ctn_pkg::is_leap(r400_reg);
        mon_b    = (mon_idx == 4'd0) ? ctn_pkg::MON_LAST : mon_idx - 4'd1;
        r400_b   = r400_reg;
        if (mon_idx == 4'd0)
        begin
            r400_b = (r400_reg == 9'd0) ? ctn_pkg::R400_LAST : r400_reg - 9'd1;
        end
        r400_c = (r400_reg == ctn_pkg::R400_LAST) ? 9'd0 : r400_reg + 9'd1;
        len_b  = ctn_pkg::month_len(ctn_pkg::is_leap(r400_b), mon_b);
        len_c  = ctn_pkg::month_len(leap_now, mon_idx);
        wk_sum = am1_reg + W'(1) + (am1_reg >>> 2) - $signed({10'b0, q100_reg})
                 + $signed({10'b0, q400_reg}) + $signed({9'b0, yday_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg && !out_ready;
        oor_next       = oor_reg;
        sec_next       = sec_reg;
        mon_next       = mon_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        mday_next      = mday_reg;
        year_next      = year_reg;
        am1_next       = am1_reg;
        r400_next      = r400_reg;
        yday_next      = yday_reg;
        q100_next      = q100_reg;
        q400_next      = q400_reg;
        wday_next      = wday_reg;
        second_next    = second_reg;
        minute_next    = minute_reg;
        hour_o_next    = hour_o_reg;
        day_o_next     = day_o_reg;
        month_o_next   = month_o_reg;
        year_o_next    = year_o_reg;
        doy_next       = doy_reg;
        wd_o_next      = wd_o_reg;
        oor_o_next     = oor_o_reg;
        div_req        = '0;
        div_state      = 1'b0;
        div_fire       = issued_reg && div_rsp.done;
        in_ready       = 1'b0;

        unique case (state_reg)
            ctn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sec_next   = second_in;
                    mon_next   = month_in;
                    min_next   = {{(W-16){minute_in[15]}}, minute_in};
                    hour_next  = {{(W-16){hour_in[15]}}, hour_in};
                    mday_next  = {{(W-16){day_in[15]}}, day_in};
                    year_next  = {{(W-13){year_in[12]}}, year_in};
                    oor_next   = 1'b0;
                    state_next = ctn_pkg::ST_SEC;
                end
            end
            ctn_pkg::ST_SEC:
            begin
                div_state        = 1'b1;
                div_req.dividend = {{(W-16){sec_reg[15]}}, sec_reg};
                div_req.divisor  = ctn_pkg::SEC_PER_MIN;
                if (div_fire)
                begin
                    sec_next   = {7'b0, div_rsp.rem};
                    min_next   = min_reg + div_rsp.quot;
                    state_next = ctn_pkg::ST_MIN;
                end
            end
            ctn_pkg::ST_MIN:
            begin
                div_state        = 1'b1;
                div_req.dividend = min_reg;
                div_req.divisor  = ctn_pkg::MIN_PER_HOUR;
                if (div_fire)
                begin
                    min_next   = {{(W-ctn_pkg::DVS_W){1'b0}}, div_rsp.rem};
                    hour_next  = hour_reg + div_rsp.quot;
                    state_next = ctn_pkg::ST_HOUR;
                end
            end
            ctn_pkg::ST_HOUR:
            begin
                div_state        = 1'b1;
                div_req.dividend = hour_reg;
                div_req.divisor  = ctn_pkg::HOUR_PER_DAY;
                if (div_fire)
                begin
                    hour_next  = {{(W-ctn_pkg::DVS_W){1'b0}}, div_rsp.rem};
                    mday_next  = mday_reg + div_rsp.quot;
                    state_next = ctn_pkg::ST_MON;
                end
            end
            ctn_pkg::ST_MON:
            begin
                div_state        = 1'b1;
                div_req.dividend = {{(W-16){mon_reg[15]}}, mon_reg};
                div_req.divisor  = ctn_pkg::MON_PER_YEAR;
                if (div_fire)
                begin
                    mon_next   = {7'b0, div_rsp.rem};
                    year_next  = year_reg + div_rsp.quot;
                    state_next = ctn_pkg::ST_Y400;
                end
            end
            ctn_pkg::ST_Y400:
            begin
                div_state        = 1'b1;
                div_req.dividend = year_reg + BASE_S;
                div_req.divisor  = ctn_pkg::CYCLE_400;
                if (div_fire)
                begin
                    r400_next  = div_rsp.rem;
                    state_next = ctn_pkg::ST_BORROW;
                end
            end
            ctn_pkg::ST_BORROW:
            begin
                if (mday_reg < W'(1))
                begin
                    mon_next  = {12'b0, mon_b};
                    r400_next = r400_b;
                    mday_next = mday_reg + $signed({{(W-5){1'b0}}, len_b});
                    if (mon_idx == 4'd0)
                    begin
                        year_next = year_reg - W'(1);
                    end
                end
                else
                begin
                    state_next = ctn_pkg::ST_CARRY;
                end
            end
            ctn_pkg::ST_CARRY:
            begin
                if (mday_reg > $signed({{(W-5){1'b0}}, len_c}))
                begin
                    mday_next = mday_reg - $signed({{(W-5){1'b0}}, len_c});
                    if (mon_idx == ctn_pkg::MON_LAST)
                    begin
                        mon_next  = '0;
                        year_next = year_reg + W'(1);
                        r400_next = r400_c;
                    end
                    else
                    begin
                        mon_next = {12'b0, mon_idx + 4'd1};
                    end
                end
                else
                begin
                    state_next = ctn_pkg::ST_CHECK;
                end
            end
            ctn_pkg::ST_CHECK:
            begin
                if (year_reg < W'(0) || year_reg > MAX_S)
                begin
                    oor_next   = 1'b1;
                    state_next = ctn_pkg::ST_OUT;
                end
                else
                begin
                    yday_next  = ctn_pkg::month_start(leap_now, mon_idx) + mday_reg[8:0] - 9'd1;
                    am1_next   = year_reg + BASE_S - W'(1);
                    state_next = ctn_pkg::ST_C100;
                end
            end
            ctn_pkg::ST_C100:
            begin
                div_state        = 1'b1;
                div_req.dividend = am1_reg;
                div_req.divisor  = ctn_pkg::CYCLE_100;
                if (div_fire)
                begin
                    q100_next  = div_rsp.quot[7:0];
                    state_next = ctn_pkg::ST_C400;
                end
            end
            ctn_pkg::ST_C400:
            begin
                div_state        = 1'b1;
                div_req.dividend = am1_reg;
                div_req.divisor  = ctn_pkg::CYCLE_400;
                if (div_fire)
                begin
                    q400_next  = div_rsp.quot[7:0];
                    state_next = ctn_pkg::ST_WDAY;
                end
            end
            ctn_pkg::ST_WDAY:
            begin
                div_state        = 1'b1;
                div_req.dividend = wk_sum;
                div_req.divisor  = ctn_pkg::DAYS_PER_WK;
                if (div_fire)
                begin
                    wday_next  = div_rsp.rem[2:0];
                    state_next = ctn_pkg::ST_OUT;
                end
            end
            ctn_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oor_o_next     = oor_reg;
                    if (oor_reg)
                    begin
                        second_next  = '0;
                        minute_next  = '0;
                        hour_o_next  = '0;
                        day_o_next   = '0;
                        month_o_next = '0;
                        year_o_next  = '0;
                        doy_next     = '0;
                        wd_o_next    = '0;
                    end
                    else
                    begin
                        second_next  = sec_reg[5:0];
                        minute_next  = min_reg[5:0];
                        hour_o_next  = hour_reg[4:0];
                        day_o_next   = mday_reg[4:0];
                        month_o_next = mon_idx;
                        year_o_next  = year_reg[11:0];
                        doy_next     = yday_reg;
                        wd_o_next    = wday_reg;
                    end
                    state_next = ctn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctn_pkg::ST_IDLE;
            end
        endcase

        // issue the division once, then wait for its done pulse
        if (div_state)
        begin
            if (!issued_reg)
            begin
                div_req.start = 1'b1;
                issued_next   = 1'b1;
            end
            else if (div_rsp.done)
            begin
                issued_next = 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign second_out   = second_reg;
    assign minute_out   = minute_reg;
    assign hour_out     = hour_o_reg;
    assign day_out      = day_o_reg;
    assign month_out    = month_o_reg;
    assign year_out     = year_o_reg;
    assign day_of_year  = doy_reg;
    assign weekday      = wd_o_reg;
    assign out_of_range = oor_o_reg;

endmodule

// ----- hw/rtl/ctn_checker.sv -----
`include "calendar_time_normalizer_top_defines.svh"

module ctn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] second_in,
    input logic [15:0] minute_in,
    input logic [15:0] hour_in,
    input logic [15:0] day_in,
    input logic [15:0] month_in,
    input logic [12:0] year_in,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  second_out,
    input logic [5:0]  minute_out,
    input logic [4:0]  hour_out,
    input logic [4:0]  day_out,
    input logic [3:0]  month_out,
    input logic [11:0] year_out,
    input logic [8:0]  day_of_year,
    input logic [2:0]  weekday,
    input logic        out_of_range
);

    logic fields_zero;
    logic fields_legal;

    assign fields_zero = (second_out == 6'd0) && (minute_out == 6'd0) && (hour_out == 5'd0)
                         && (day_out == 5'd0) && (month_out == 4'd0) && (year_out == 12'd0)
                         && (day_of_year == 9'd0) && (weekday == 3'd0);

    assign fields_legal = (second_out <= 6'd59) && (minute_out <= 6'd59) && (hour_out <= 5'd23)
                          && (day_out != 5'd0) && (month_out <= 4'd11)
                          && (day_of_year <= 9'd365) && (weekday <= 3'd6);

    `CTN_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `CTN_ASSERT_IMP(a_oor_zero, out_valid && out_of_range, fields_zero, "oor fields not zero")
    `CTN_ASSERT_IMP(a_fields_legal, out_valid && !out_of_range, fields_legal, "field out of range")
    `CTN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(weekday), "result dropped")

endmodule

bind calendar_time_normalizer_top ctn_checker u_ctn_checker (.*);
